// File: design/unsigned_to_radix_digits_assert.svh
// assertion macros used by the checker file of unsigned_to_radix_digits
// depends on nothing; include by bare file name
`ifndef UNSIGNED_TO_RADIX_DIGITS_ASSERT_SVH
`define UNSIGNED_TO_RADIX_DIGITS_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define URD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("urd: same-cycle check failed");

// next-cycle implication, held off while reset is low
`define URD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("urd: next-cycle check failed");

`endif

// File: design/urd_pkg.sv
// shared constants, types and helpers for unsigned_to_radix_digits
// no dependencies
package urd_pkg;

  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int CHUNK_W        = 8;
  localparam int QUEUE_DEPTH    = 2;
  localparam int OUT_DEPTH      = 2;
  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;

  // divide unit control and status
  typedef struct packed {
    logic go;
    logic load;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end
    return c;
  endfunction

endpackage

// File: design/unsigned_to_radix_digits.sv
// top level of the unsigned-to-radix-digit converter
// depends on urd_pkg, urd_front, urd_div and urd_back
//
// Converts each unsigned value pushed on the input queue into ASCII digits in the
// configured base (2 to 36, reset 10; codes 0 and 1 act as 2, codes above 36 act
// as 36) and delivers one result per digit, most significant first, '0'-'9' then
// 'A'-'Z'. Zero gives the single digit '0'. The final digit carries last_digit, and
// every digit carries the total digit count; a number needing more than MAX_DIGITS
// digits yields only its MAX_DIGITS least significant ones. The radix may only be
// written while the block is idle. One number is converted at a time. For each
// digit the divide unit takes in the remaining quotient, then divides it one byte
// at a time, starting from its highest nonzero byte (the byte-wide divide unit is
// the bottleneck); then the digits stream out of the digit store at one per cycle
// while the result queue has room. Up to two requests wait in the input queue and
// up to two results in the output queue, so each side may stall independently.
module unsigned_to_radix_digits import urd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request queue side
  input  logic               in_push,
  output logic               in_full,
  input  logic [VALUE_W-1:0] in_value,
  // result queue side
  output logic               out_empty,
  input  logic               out_pop,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit,
  output logic [COUNT_W-1:0] out_digit_count,
  // radix register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data
);

  // front to back queue
  logic                  q_valid;
  logic                  q_take;
  logic [VALUE_BITS-1:0] q_value;
  logic [RADIX_W-1:0]    q_radix;

  // sequencer to divide unit
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [RADIX_W-1:0]    div_digit;

  // front: radix register, base clamping, value masking and request queue
  urd_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_value  (q_value),
    .q_radix  (q_radix),
    .q_take   (q_take)
  );

  // divide unit: quotient kept in place, remainder is the next digit
  urd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (div_ctrl),
    .value_in(q_value),
    .radix_in(q_radix),
    .stat    (div_stat),
    .digit   (div_digit)
  );

  // back: collects digits, then replays them in reverse into the result queue
  urd_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .div_ctrl       (div_ctrl),
    .div_stat       (div_stat),
    .div_digit      (div_digit),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_digit_count(out_digit_count)
  );

endmodule

// File: design/urd_front.sv
// front part: radix register, request acceptance and a short request queue
// depends on urd_pkg
module urd_front import urd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VALUE_W-1:0]    in_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_W-1:0]    cfg_data,
  output logic                  q_valid,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [RADIX_W-1:0]    q_radix,
  input  logic                  q_take
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    radix_eff;
  logic [VALUE_BITS-1:0] val_q_r [QUEUE_DEPTH];
  logic [RADIX_W-1:0]    rad_q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_data;
    end
  end

  // out-of-range bases fold onto the nearest legal one
  always_comb begin
    if (radix_r inside {[6'd0:6'd1]}) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r inside {[6'd37:6'd63]}) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  assign in_full = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push    = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_value = val_q_r[rd_ptr_r];
  assign q_radix = rad_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (q_take) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !q_take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && q_take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_q_r[wr_ptr_r] <= in_value[VALUE_BITS-1:0];
      rad_q_r[wr_ptr_r] <= radix_eff;
    end
  end

endmodule

// File: design/urd_div.sv
// iterative divide-by-radix unit, one byte of the dividend per cycle
// depends on urd_pkg
module urd_div import urd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_ctrl_t             ctrl,
  input  logic [VALUE_BITS-1:0] value_in,
  input  logic [RADIX_W-1:0]    radix_in,
  output div_stat_t             stat,
  output logic [RADIX_W-1:0]    digit
);

  localparam int CHUNKS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W  = CHUNKS * CHUNK_W;
  localparam int IDX_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [PAD_W-1:0]   val_r, val_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic [RADIX_W-1:0] radix_r, radix_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [PAD_W-1:0]   src;
  logic [IDX_W-1:0]   top;
  logic [CHUNK_W-1:0] chunk_in;
  logic [CHUNK_W-1:0] chunk_q;
  logic [RADIX_W-1:0] rem_step;

  assign src = ctrl.load ? PAD_W'(value_in) : val_r;

  // highest nonzero byte: leading zero bytes are skipped
  always_comb begin
    top = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (src[c*CHUNK_W +: CHUNK_W] != '0) begin
        top = IDX_W'(c);
      end
    end
  end

  // restoring long division over one byte
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    chunk_in = val_r[idx_r*CHUNK_W +: CHUNK_W];
    r        = rem_r;
    chunk_q  = '0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      t = {r, chunk_in[b]};
      if (t >= {1'b0, radix_r}) begin
        chunk_q[b] = 1'b1;
        r          = RADIX_W'(t - {1'b0, radix_r});
      end else begin
        r = t[RADIX_W-1:0];
      end
    end
    rem_step = r;
  end

  always_comb begin
    val_nxt   = val_r;
    rem_nxt   = rem_r;
    radix_nxt = radix_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctrl.go) begin
      val_nxt  = src;
      rem_nxt  = '0;
      idx_nxt  = top;
      busy_nxt = 1'b1;
      if (ctrl.load) begin
        radix_nxt = radix_in;
      end
    end else if (busy_r) begin
      val_nxt[idx_r*CHUNK_W +: CHUNK_W] = chunk_q;
      rem_nxt = rem_step;
      if (idx_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    idx_r   <= idx_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quo_zero = (val_r == '0);
  assign digit         = rem_r;

endmodule

// File: design/urd_back.sv
// back part: digit sequencer, digit store and result queue
// depends on urd_pkg
module urd_back import urd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  output div_ctrl_t          div_ctrl,
  input  div_stat_t          div_stat,
  input  logic [RADIX_W-1:0] div_digit,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [CHAR_W-1:0]  out_digit_char,
  output logic               out_last_digit,
  output logic [COUNT_W-1:0] out_digit_count
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CW    = $clog2(MAX_DIGITS + 1);
  localparam int OPW   = $clog2(OUT_DEPTH);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      rd_left_r, rd_left_nxt;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      n_inc;
  logic               wr_en;
  logic               issue;
  logic               can_issue;

  logic [RADIX_W-1:0] store [MAX_DIGITS];
  logic [RADIX_W-1:0] rd_data_r;
  logic               rd_valid_r;
  logic               rd_last_r;
  logic [CW-1:0]      rd_cnt_r;

  logic [CHAR_W-1:0]  oq_char_r  [OUT_DEPTH];
  logic               oq_last_r  [OUT_DEPTH];
  logic [COUNT_W-1:0] oq_count_r [OUT_DEPTH];
  logic [OPW-1:0]     oq_wr_r, oq_wr_nxt;
  logic [OPW-1:0]     oq_rd_r, oq_rd_nxt;
  logic [OCW-1:0]     oq_cnt_r, oq_cnt_nxt;
  logic               pop;
  logic [OCW:0]       occ;

  assign n_inc  = n_r + CW'(1);
  assign rd_idx = rd_left_r - CW'(1);
  assign pop    = out_pop && !out_empty;

  // room counts reads in flight and a pop in this cycle
  assign occ       = (OCW+1)'(oq_cnt_r) + (OCW+1)'(rd_valid_r) - (OCW+1)'(pop);
  assign can_issue = (occ < (OCW+1)'(OUT_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rd_left_nxt   = rd_left_r;
    q_take        = 1'b0;
    div_ctrl.go   = 1'b0;
    div_ctrl.load = 1'b0;
    wr_en         = 1'b0;
    issue         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take        = 1'b1;
          div_ctrl.go   = 1'b1;
          div_ctrl.load = 1'b1;
          n_nxt         = '0;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          wr_en = 1'b1;
          n_nxt = n_inc;
          if (div_stat.quo_zero || n_inc == CW'(MAX_DIGITS)) begin
            rd_left_nxt = n_inc;
            state_nxt   = ST_EMIT;
          end else begin
            div_ctrl.go = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (can_issue) begin
          issue       = 1'b1;
          rd_left_nxt = rd_idx;
          if (rd_left_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      n_r        <= '0;
      rd_left_r  <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      rd_left_r  <= rd_left_nxt;
      rd_valid_r <= issue;
    end
  end

  // digit store, least significant digit at the lowest address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[n_r[AW-1:0]] <= div_digit;
    end
    if (issue) begin
      rd_data_r <= store[rd_idx[AW-1:0]];
      rd_last_r <= (rd_left_r == CW'(1));
      rd_cnt_r  <= n_r;
    end
  end

  // result queue
  always_comb begin
    oq_wr_nxt  = oq_wr_r;
    oq_rd_nxt  = oq_rd_r;
    oq_cnt_nxt = oq_cnt_r;
    if (rd_valid_r) begin
      oq_wr_nxt = (oq_wr_r == OPW'(OUT_DEPTH - 1)) ? '0 : oq_wr_r + OPW'(1);
    end
    if (pop) begin
      oq_rd_nxt = (oq_rd_r == OPW'(OUT_DEPTH - 1)) ? '0 : oq_rd_r + OPW'(1);
    end
    if (rd_valid_r && !pop) begin
      oq_cnt_nxt = oq_cnt_r + OCW'(1);
    end else if (!rd_valid_r && pop) begin
      oq_cnt_nxt = oq_cnt_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      oq_char_r[oq_wr_r]  <= digit_to_char(rd_data_r);
      oq_last_r[oq_wr_r]  <= rd_last_r;
      oq_count_r[oq_wr_r] <= COUNT_W'(rd_cnt_r);
    end
  end

  assign out_empty       = (oq_cnt_r == '0);
  assign out_digit_char  = oq_char_r[oq_rd_r];
  assign out_last_digit  = oq_last_r[oq_rd_r];
  assign out_digit_count = oq_count_r[oq_rd_r];

endmodule

// File: design/urd_checker.sv
// port-level checks for unsigned_to_radix_digits, bound to the top level
// depends on urd_pkg and unsigned_to_radix_digits_assert.svh
`include "unsigned_to_radix_digits_assert.svh"

module urd_checker import urd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic [CHAR_W-1:0]  out_digit_char,
  input logic               out_last_digit,
  input logic [COUNT_W-1:0] out_digit_count
);

  // a shown digit is always a legal character
  `URD_ASSERT_IMP(a_char_legal, clk, rst_n, !out_empty, ((out_digit_char >= 7'h30 && out_digit_char <= 7'h39) || (out_digit_char >= 7'h41 && out_digit_char <= 7'h5A)))

  // digit count stays within the store size
  `URD_ASSERT_IMP(a_count_range, clk, rst_n, !out_empty, (out_digit_count != '0 && out_digit_count <= COUNT_W'(MAX_DIGITS)))

  // digits of one number all carry the same count
  `URD_ASSERT_NXT(a_count_same, clk, rst_n, (out_pop && !out_empty && !out_last_digit), (out_empty || $stable(out_digit_count)))

  // a waiting result holds until taken
  `URD_ASSERT_NXT(a_hold, clk, rst_n, (!out_empty && !out_pop), (!out_empty && $stable(out_digit_char) && $stable(out_last_digit)))

endmodule

bind unsigned_to_radix_digits urd_checker #(
  .MAX_DIGITS(MAX_DIGITS)
) u_urd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit),
  .out_digit_count(out_digit_count)
);

// File: test/tb.sv
// self-checking testbench for unsigned_to_radix_digits: converts values in many bases
// depends on urd_pkg and the unsigned_to_radix_digits top level from the design folder
`timescale 1ns / 1ps

module tb;
  import urd_pkg::*;

  // one expected digit result
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } digit_t;

  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 1500;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic [CHAR_W-1:0]  out_digit_char;
  logic               out_last_digit;
  logic [COUNT_W-1:0] out_digit_count;
  logic               cfg_valid = 1'b0;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               cfg_ready;

  // values queued for the driver, and digits still owed by the block
  logic [VALUE_W-1:0] values_waiting[$];
  digit_t             digits_due[$];
  digit_t             want;

  // radix as the block should currently see it (reset value until written)
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int mismatches = 0;
  logic hold_pop = 1'b0;
  logic hold_start = 1'b0;

  unsigned_to_radix_digits dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_value        (in_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_digit_char  (out_digit_char),
    .out_last_digit  (out_last_digit),
    .out_digit_count (out_digit_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // work out the digit string of one value and queue it, most significant first
  function automatic void expand_digits(input logic [VALUE_W-1:0] v,
                                        input logic [RADIX_W-1:0] code);
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] base;
    logic [RADIX_W-1:0] held[MAX_DIGITS_DEF];
    int n;
    digit_t d;
    // codes below two act as two, codes above thirty-six as thirty-six
    if (code < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (code > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end else begin
      base = VALUE_W'(code);
    end
    rest = v;
    n = 0;
    // remainders come out least significant first; zero still gives one digit
    do begin
      held[n] = RADIX_W'(rest % base);
      n++;
      rest = rest / base;
    end while (rest != 0 && n < MAX_DIGITS_DEF);
    for (int k = n - 1; k >= 0; k--) begin
      if (held[k] < DEC_LIMIT) begin
        d.ch = CHAR_ZERO + CHAR_W'(held[k]);
      end else begin
        d.ch = CHAR_A + CHAR_W'(held[k] - DEC_LIMIT);
      end
      d.last  = (k == 0);
      d.count = COUNT_W'(n);
      digits_due.push_back(d);
    end
  endfunction

  // mix of full-width, shortened, small and power-of-two values
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(4))
      0, 1: begin
        v = {$urandom, $urandom};
      end
      2: begin
        v = {$urandom, $urandom} >> $urandom_range(VALUE_W - 1);
      end
      3: begin
        v = VALUE_W'($urandom_range(1000));
      end
      default: begin
        v = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
        if ($urandom_range(1)) begin
          v = v - 1;
        end
        if ($urandom_range(7) == 0) begin
          v = '1;
        end
      end
    endcase
    return v;
  endfunction

  // driver: offers the head of values_waiting, holds it while the block is full
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        // request taken: predict with the radix in force now
        expand_digits(in_value, radix_now);
        void'(values_waiting.pop_front());
      end
      if (in_push && in_full) begin
        // keep offering the same request until there is room
        in_push <= 1'b1;
      end else if (values_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push  <= 1'b1;
        in_value <= values_waiting[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: pops results at random and checks each against the oldest digit owed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (digits_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result char %h last %b count %0d", $time,
                   out_digit_char, out_last_digit, out_digit_count);
        end else begin
          want = digits_due.pop_front();
          if (out_digit_char !== want.ch) begin
            mismatches++;
            $display("%0t: digit_char expected %h actual %h", $time, want.ch, out_digit_char);
          end
          if (out_last_digit !== want.last) begin
            mismatches++;
            $display("%0t: last_digit expected %b actual %b", $time, want.last,
                     out_last_digit);
          end
          if (out_digit_count !== want.count) begin
            mismatches++;
            $display("%0t: digit_count expected %0d actual %0d", $time, want.count,
                     out_digit_count);
          end
        end
      end
      out_pop <= !hold_pop && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // long receiver hold-off so that both internal queues fill and in_full rises
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 1'b0;
  end

  // wait until every request is taken and every digit has come back
  task automatic wait_idle();
    while (values_waiting.size() != 0 || digits_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // radix register write, only called while the block is idle
  task automatic write_radix(input logic [RADIX_W-1:0] code);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_now = code;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct <= 0;
        pop_stall_pct <= 0;
      end
      1: begin
        send_idle_pct <= 51;
        pop_stall_pct <= 0;
      end
      2: begin
        send_idle_pct <= 0;
        pop_stall_pct <= 51;
      end
      default: begin
        send_idle_pct <= 26;
        pop_stall_pct <= 26;
      end
    endcase
  endtask

  // reset, directed values, then random phases over several radix settings
  initial begin
    logic [RADIX_W-1:0] phase_radix[8];
    phase_radix = '{6'd10, 6'd2, 6'd36, 6'($urandom_range(3, 35)), 6'd0, 6'd63,
                    6'($urandom_range(37, 62)), 6'($urandom_range(63))};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix (ten): zero, one, digit boundaries, widest values
    values_waiting.push_back(64'd0);
    values_waiting.push_back(64'd1);
    values_waiting.push_back(64'd9);
    values_waiting.push_back(64'd10);
    values_waiting.push_back(64'd12345678901234567890);
    values_waiting.push_back('1);
    wait_idle();

    // base two: the full 64-digit string and single bits
    write_radix(RADIX_MIN);
    values_waiting.push_back(64'd0);
    values_waiting.push_back('1);
    values_waiting.push_back(64'h8000_0000_0000_0000);
    values_waiting.push_back(64'd1);
    wait_idle();

    // base thirty-six: letters up to 'Z'
    write_radix(RADIX_MAX);
    values_waiting.push_back(64'd35);
    values_waiting.push_back(64'd36);
    values_waiting.push_back('1);
    values_waiting.push_back(64'h0123_4567_89AB_CDEF);
    wait_idle();

    // radix codes below two behave as base two
    write_radix(6'd0);
    values_waiting.push_back(64'd5);
    wait_idle();
    write_radix(6'd1);
    values_waiting.push_back(64'hAAAA_5555_AAAA_5555);
    wait_idle();

    // radix codes above thirty-six behave as base thirty-six
    write_radix(6'd63);
    values_waiting.push_back(64'd35);
    values_waiting.push_back('1);
    wait_idle();
    write_radix(6'd37);
    values_waiting.push_back(64'd36);
    values_waiting.push_back(64'd1295);
    wait_idle();

    // random phases, idling mode cycles through all four
    for (int p = 0; p < 8; p++) begin
      write_radix(phase_radix[p]);
      set_idling(p % 4);
      if (p == 0) begin
        hold_start = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        values_waiting.push_back(rand_value());
      end
      wait_idle();
    end

    // drain window, then the verdict
    set_idling(0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/urd_pkg.sv
design/urd_front.sv
design/urd_div.sv
design/urd_back.sv
design/unsigned_to_radix_digits.sv
design/urd_checker.sv
test/tb.sv
